// ===== design/vddp_pkg.sv =====
// shared types and constants for the varint delta posting decoder
`timescale 1ns / 1ps

package vddp_pkg;

  // default id width
  localparam int ID_WIDTH_DEF = 32;

  // varint byte layout
  localparam int BYTE_BITS   = 8;
  localparam int GROUP_BITS  = 7;
  localparam int MORE_BIT    = 7;
  localparam int MAX_GROUPS  = 5;
  localparam int COUNT_BITS  = 3;
  localparam int SHIFT_BITS  = 5;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_TOO_LONG  = 2'd1,
    ST_TRUNCATED = 2'd2
  } status_t;

  // one input item
  typedef struct packed {
    logic [BYTE_BITS-1:0] data_byte;
    logic                 list_start;
    logic                 list_last;
  } item_t;

  // result control from decode core to output register
  typedef struct packed {
    logic    vld;
    status_t status;
  } res_ctl_t;

endpackage

// ===== design/vddp_in_reg.sv =====
// input register stage holding one accepted byte item
`timescale 1ns / 1ps

module vddp_in_reg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  vddp_pkg::item_t in_item,
  input  logic          adv,
  output logic          item_vld,
  output vddp_pkg::item_t item
);

  logic            vld_r;
  logic            vld_nxt;
  vddp_pkg::item_t item_r;
  logic            take;

  // hold the item only while the next stage cannot move
  assign in_stall = vld_r && !adv;
  assign take     = in_valid && !in_stall;

  always_comb begin
    vld_nxt = vld_r;
    if (take) begin
      vld_nxt = 1'b1;
    end else if (adv) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
    if (take) begin
      item_r <= in_item;
    end
  end

  assign item_vld = vld_r;
  assign item     = item_r;

endmodule

// ===== design/vddp_core.sv =====
// varint gathering and delta accumulation with decoder state
`timescale 1ns / 1ps

module vddp_core #(
  parameter int ID_WIDTH = vddp_pkg::ID_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  vddp_pkg::item_t     item,
  output vddp_pkg::res_ctl_t  res,
  output logic [ID_WIDTH-1:0] res_id
);

  localparam int CW = vddp_pkg::COUNT_BITS;
  localparam int SW = vddp_pkg::SHIFT_BITS;
  localparam int GB = vddp_pkg::GROUP_BITS;

  logic [ID_WIDTH-1:0] gap_r, gap_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [ID_WIDTH-1:0] run_r, run_nxt;
  logic                halt_r, halt_nxt;

  logic [ID_WIDTH-1:0] base_gap;
  logic [CW-1:0]       base_cnt;
  logic [ID_WIDTH-1:0] base_run;
  logic                base_halt;
  logic [SW-1:0]       shift;
  logic [ID_WIDTH-1:0] grp;
  logic [ID_WIDTH-1:0] gap_new;
  logic [ID_WIDTH-1:0] sum;

  // list start clears state before the byte is decoded
  assign base_gap  = item.list_start ? '0 : gap_r;
  assign base_cnt  = item.list_start ? '0 : cnt_r;
  assign base_run  = item.list_start ? '0 : run_r;
  assign base_halt = item.list_start ? 1'b0 : halt_r;

  // place the seven-bit group; bits beyond the id width drop off
  assign shift   = SW'(base_cnt) * SW'(GB);
  assign grp     = {{(ID_WIDTH-GB){1'b0}}, item.data_byte[GB-1:0]} << shift;
  assign gap_new = base_gap | grp;
  assign sum     = base_run + gap_new;

  // decode one byte
  always_comb begin
    gap_nxt    = base_gap;
    cnt_nxt    = base_cnt;
    run_nxt    = base_run;
    halt_nxt   = base_halt;
    res.vld    = 1'b0;
    res.status = vddp_pkg::ST_OK;
    res_id     = '0;
    priority if (base_halt) begin
      // ignore bytes until the next list start
    end else if (base_cnt >= CW'(vddp_pkg::MAX_GROUPS)) begin
      gap_nxt    = '0;
      cnt_nxt    = '0;
      halt_nxt   = 1'b1;
      res.vld    = 1'b1;
      res.status = vddp_pkg::ST_TOO_LONG;
    end else if (item.data_byte[vddp_pkg::MORE_BIT]) begin
      if (item.list_last) begin
        gap_nxt    = '0;
        cnt_nxt    = '0;
        halt_nxt   = 1'b1;
        res.vld    = 1'b1;
        res.status = vddp_pkg::ST_TRUNCATED;
      end else begin
        gap_nxt = gap_new;
        cnt_nxt = base_cnt + CW'(1);
      end
    end else begin
      gap_nxt    = '0;
      cnt_nxt    = '0;
      run_nxt    = sum;
      res.vld    = 1'b1;
      res.status = vddp_pkg::ST_OK;
      res_id     = sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_r  <= '0;
      cnt_r  <= '0;
      run_r  <= '0;
      halt_r <= 1'b0;
    end else if (fire) begin
      gap_r  <= gap_nxt;
      cnt_r  <= cnt_nxt;
      run_r  <= run_nxt;
      halt_r <= halt_nxt;
    end
  end

endmodule

// ===== design/vddp_out_reg.sv =====
// result register facing the output channel
`timescale 1ns / 1ps

module vddp_out_reg #(
  parameter int ID_WIDTH = vddp_pkg::ID_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                item_vld,
  input  vddp_pkg::res_ctl_t  res,
  input  logic [ID_WIDTH-1:0] res_id,
  output logic                adv,
  output logic                fire,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [ID_WIDTH-1:0] out_doc_id,
  output logic [1:0]          out_status
);

  logic                vld_r, vld_nxt;
  logic [ID_WIDTH-1:0] id_r;
  vddp_pkg::status_t   st_r;

  // the slot moves when empty or when its item is taken
  assign adv  = !vld_r || !out_stall;
  assign fire = item_vld && adv;

  always_comb begin
    vld_nxt = vld_r;
    if (adv) begin
      vld_nxt = fire && res.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
    if (adv) begin
      id_r <= res_id;
      st_r <= res.status;
    end
  end

  assign out_valid  = vld_r;
  assign out_doc_id = id_r;
  assign out_status = st_r;

endmodule

// ===== design/varint_delta_posting_decoder.sv =====
// Varint delta posting list decoder, top level.
// Input channel: one encoded byte per item (in_data_byte) with in_list_start
// marking the first byte of a list and in_list_last its final byte. An item
// is taken on a clock edge with in_valid high and in_stall low.
// Output channel: out_doc_id and out_status; status 0 is a decoded id,
// 1 a varint longer than five bytes, 2 a list that ended inside a varint.
// Continuation bytes, unless ending a list or sixth in a varint, and bytes
// after an error give no result; a list start clears the running id and
// the error. An accepted byte is held in the input register, then decoded
// into the result register.
// Throughput: one byte per cycle while out_stall stays low; the decode step
// (shift, or and ID_WIDTH-bit add) is combinational between the registers.
// Reset (rst_n low, synchronous) empties both registers and clears the
// running id, the partial varint and the error flag.
// When the receiver holds out_stall, the result stays unchanged; if the
// input register is empty, one more byte is taken into it, then in_stall
// rises until the result is taken.
`timescale 1ns / 1ps

module varint_delta_posting_decoder #(
  parameter int ID_WIDTH = vddp_pkg::ID_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          in_data_byte,
  input  logic                in_list_start,
  input  logic                in_list_last,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [ID_WIDTH-1:0] out_doc_id,
  output logic [1:0]          out_status
);

  vddp_pkg::item_t    in_item;
  vddp_pkg::item_t    item;
  logic               item_vld;
  logic               adv;
  logic               fire;
  vddp_pkg::res_ctl_t res;
  logic [ID_WIDTH-1:0] res_id;

  assign in_item.data_byte  = in_data_byte;
  assign in_item.list_start = in_list_start;
  assign in_item.list_last  = in_list_last;

  // input register
  vddp_in_reg u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .adv      (adv),
    .item_vld (item_vld),
    .item     (item)
  );

  // decode state and logic
  vddp_core #(.ID_WIDTH(ID_WIDTH)) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .item   (item),
    .res    (res),
    .res_id (res_id)
  );

  // result register
  vddp_out_reg #(.ID_WIDTH(ID_WIDTH)) u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_vld   (item_vld),
    .res        (res),
    .res_id     (res_id),
    .adv        (adv),
    .fire       (fire),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_doc_id (out_doc_id),
    .out_status (out_status)
  );

endmodule

// ===== design/vddp_checker.sv =====
// port-level checks for the varint delta posting decoder, bound to the top
`timescale 1ns / 1ps

module vddp_checker #(
  parameter int ID_WIDTH = vddp_pkg::ID_WIDTH_DEF
) (
  input logic                clk,
  input logic                rst_n,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input logic [ID_WIDTH-1:0] out_doc_id,
  input logic [1:0]          out_status
);

  // no result is shown right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // error results carry a zero id
  a_err_zero_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != vddp_pkg::ST_OK |-> out_doc_id == '0)
    else $error("error result with nonzero id");

  // status codes stay within the defined set
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == vddp_pkg::ST_OK || out_status == vddp_pkg::ST_TOO_LONG ||
                   out_status == vddp_pkg::ST_TRUNCATED))
    else $error("undefined status code");

  // input is not held back while the output side is free
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_doc_id) && $stable(out_status))
    else $error("stalled result changed");

endmodule

bind varint_delta_posting_decoder vddp_checker #(.ID_WIDTH(ID_WIDTH)) u_vddp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_doc_id (out_doc_id),
  .out_status (out_status)
);

// ===== verif/varint_delta_posting_decoder_tb.sv =====
// self-checking testbench for the varint delta posting list decoder
`timescale 1ns / 1ps

module varint_delta_posting_decoder_tb;

  localparam int ID_W        = 32;
  localparam int LAST_SHIFT  = (vddp_pkg::MAX_GROUPS - 1) * vddp_pkg::GROUP_BITS;
  localparam int TARGET_BYTES = 1550;
  localparam int TAIL_BYTES  = 150;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 8;

  // expected decoder output
  typedef struct {
    logic [ID_W-1:0]   doc_id;
    vddp_pkg::status_t status;
  } doc_result_t;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_stall;
  logic [7:0]      in_data_byte = '0;
  logic            in_list_start = 1'b0;
  logic            in_list_last = 1'b0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  logic [ID_W-1:0] out_doc_id;
  logic [1:0]      out_status;

  varint_delta_posting_decoder dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data_byte  (in_data_byte),
    .in_list_start (in_list_start),
    .in_list_last  (in_list_last),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_doc_id    (out_doc_id),
    .out_status    (out_status)
  );

  // encoded byte stream and decoded ids still owed by the block
  vddp_pkg::item_t byte_queue[$];
  doc_result_t     expected_ids[$];

  // decoder state mirror
  logic [ID_W-1:0] gap_sum;
  logic [2:0]      groups;
  logic [ID_W-1:0] cur_id;
  logic            dead;

  int  mismatches = 0;
  int  cycle_count = 0;
  int  bytes_taken = 0;
  int  ids_seen = 0;
  int  overlong_seen = 0;
  int  truncated_seen = 0;
  int  lists_built = 0;
  bit  byte_taken = 1'b0;
  int  idle_left = 0;
  int  stall_left = 0;

  // clock
  initial begin
    forever #2 clk = ~clk;
  end

  function automatic bit in_tail();
    return byte_queue.size() < TAIL_BYTES;
  endfunction

  task automatic flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch @%0t: %s", $realtime, msg);
  endtask

  // one decode step of the mirror; returns 1 when the byte yields a result
  function automatic bit decode_byte(input vddp_pkg::item_t it, output doc_result_t res);
    int sh;
    res.doc_id = '0;
    res.status = vddp_pkg::ST_OK;
    if (it.list_start) begin
      gap_sum = '0;
      groups  = '0;
      cur_id  = '0;
      dead    = 1'b0;
    end
    if (dead) return 1'b0;
    // sixth byte of one varint wins over truncation
    if (groups >= vddp_pkg::MAX_GROUPS) begin
      gap_sum    = '0;
      groups     = '0;
      dead       = 1'b1;
      res.status = vddp_pkg::ST_TOO_LONG;
      return 1'b1;
    end
    sh = groups * vddp_pkg::GROUP_BITS;
    if (sh > LAST_SHIFT) sh = LAST_SHIFT;
    gap_sum = gap_sum | (ID_W'(it.data_byte[vddp_pkg::GROUP_BITS-1:0]) << sh);
    groups  = groups + 3'd1;
    if (it.data_byte[vddp_pkg::MORE_BIT]) begin
      // list ended inside a varint
      if (it.list_last) begin
        gap_sum    = '0;
        groups     = '0;
        dead       = 1'b1;
        res.status = vddp_pkg::ST_TRUNCATED;
        return 1'b1;
      end
      return 1'b0;
    end
    cur_id     = cur_id + gap_sum;
    gap_sum    = '0;
    groups     = '0;
    res.doc_id = cur_id;
    return 1'b1;
  endfunction

  // stimulus building
  task automatic add_byte(input logic [7:0] b, input bit s, input bit l);
    vddp_pkg::item_t it;
    it.data_byte  = b;
    it.list_start = s;
    it.list_last  = l;
    byte_queue.push_back(it);
  endtask

  task automatic add_varint(input logic [31:0] gap, input int nbytes, input logic [2:0] junk,
                            input bit s, input bit l);
    logic [7:0] b;
    for (int i = 0; i < nbytes; i++) begin
      b = 8'((gap >> (vddp_pkg::GROUP_BITS * i)) & 32'h7F);
      // fifth group: upper bits fall beyond the id width
      if (i == vddp_pkg::MAX_GROUPS - 1) b[6:4] = junk;
      if (i < nbytes - 1) b[vddp_pkg::MORE_BIT] = 1'b1;
      add_byte(b, s && (i == 0), l && (i == nbytes - 1));
    end
  endtask

  // one randomly shaped list: mostly well formed, some broken, some noise
  task automatic add_random_list();
    int         n_ids;
    int         kind;
    int         nbytes;
    int         r;
    bit         s_next;
    bit         close_list;
    logic [31:0] gap;
    s_next     = 1'b1;
    n_ids      = $urandom_range(1, 8);
    kind       = $urandom_range(0, 99);
    close_list = ($urandom_range(0, 3) != 0);
    lists_built++;
    if (kind >= 96) begin
      // noise with random flags
      n_ids = $urandom_range(3, 10);
      for (int i = 0; i < n_ids; i++)
        add_byte(8'($urandom), ($urandom_range(0, 7) == 0), ($urandom_range(0, 3) == 0));
      return;
    end
    if (kind >= 80) n_ids = $urandom_range(0, 3);
    for (int k = 0; k < n_ids; k++) begin
      r = $urandom_range(0, 9);
      nbytes = (r < 4) ? 1 : (r < 6) ? 2 : (r < 7) ? 3 : (r < 8) ? 4 : 5;
      gap = $urandom;
      if (nbytes < vddp_pkg::MAX_GROUPS)
        gap = gap & ((32'd1 << (vddp_pkg::GROUP_BITS * nbytes)) - 1);
      add_varint(gap, nbytes, 3'($urandom), s_next,
                 (kind < 80) && close_list && (k == n_ids - 1));
      s_next = 1'b0;
    end
    if (kind >= 88) begin
      // truncated varint at the end of the list
      nbytes = $urandom_range(1, 4);
      for (int i = 0; i < nbytes; i++) begin
        add_byte(8'($urandom) | 8'h80, s_next, i == nbytes - 1);
        s_next = 1'b0;
      end
    end else if (kind >= 80) begin
      // overlong varint, sixth byte random
      for (int i = 0; i < vddp_pkg::MAX_GROUPS; i++) begin
        add_byte(8'($urandom) | 8'h80, s_next, 1'b0);
        s_next = 1'b0;
      end
      add_byte(8'($urandom), 1'b0, 1'($urandom_range(0, 1)));
    end
    // bytes after an error are dropped
    if (kind >= 80 && $urandom_range(0, 1) == 1) begin
      for (int i = 0; i < $urandom_range(1, 3); i++)
        add_byte(8'($urandom), 1'b0, 1'($urandom_range(0, 1)));
    end
  endtask

  // input driver
  always @(negedge clk) begin
    vddp_pkg::item_t it;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !byte_taken) begin
      // hold the stalled item
    end else if (idle_left > 0) begin
      idle_left--;
      in_valid <= 1'b0;
    end else if (!in_tail() && $urandom_range(0, 7) == 0) begin
      idle_left = $urandom_range(0, 14);
      in_valid <= 1'b0;
    end else if (byte_queue.size() > 0) begin
      it = byte_queue.pop_front();
      in_valid      <= 1'b1;
      in_data_byte  <= it.data_byte;
      in_list_start <= it.list_start;
      in_list_last  <= it.list_last;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (!in_tail() && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 14);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // monitor and prediction
  always @(posedge clk) begin
    vddp_pkg::item_t it;
    doc_result_t     want;
    doc_result_t     got;
    byte_taken = 1'b0;
    if (!rst_n) begin
      gap_sum = '0;
      groups  = '0;
      cur_id  = '0;
      dead    = 1'b0;
    end else begin
      // check a taken result against the oldest expectation
      if (out_valid && !out_stall) begin
        got.doc_id = out_doc_id;
        got.status = vddp_pkg::status_t'(out_status);
        if (got.status == vddp_pkg::ST_OK) ids_seen++;
        else if (got.status == vddp_pkg::ST_TOO_LONG) overlong_seen++;
        else truncated_seen++;
        if (expected_ids.size() == 0) begin
          flag_mismatch($sformatf("unexpected result doc_id=%h status=%0d",
                                  out_doc_id, out_status));
        end else begin
          want = expected_ids.pop_front();
          if (got.doc_id !== want.doc_id || got.status !== want.status)
            flag_mismatch($sformatf("doc_id exp %h got %h, status exp %0d got %0d",
                                    want.doc_id, got.doc_id, want.status, out_status));
        end
      end
      // predict for a taken item
      if (in_valid && !in_stall) begin
        byte_taken    = 1'b1;
        bytes_taken++;
        it.data_byte  = in_data_byte;
        it.list_start = in_list_start;
        it.list_last  = in_list_last;
        if (decode_byte(it, want)) expected_ids.push_back(want);
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_ids.size());
      $display("** varint_delta_posting_decoder: FAILED **");
      $finish;
    end
  end

  // stimulus and end of run
  initial begin
    // directed: zero gap, single-byte max, five-byte max with dropped bits
    add_varint(32'd0, 1, 3'd0, 1'b1, 1'b0);
    add_varint(32'd127, 1, 3'd0, 1'b0, 1'b0);
    add_varint(32'hFFFF_FFFF, 5, 3'b111, 1'b0, 1'b0);
    // padded zero
    add_varint(32'd0, 3, 3'd0, 1'b0, 1'b0);
    // overlong varint, last flag on the sixth byte too
    for (int i = 0; i < vddp_pkg::MAX_GROUPS; i++) add_byte(8'hFF, 1'b0, 1'b0);
    add_byte(8'h81, 1'b0, 1'b1);
    // ignored while halted
    add_byte(8'h05, 1'b0, 1'b0);
    add_byte(8'h83, 1'b0, 1'b1);
    // one-byte list cut off inside a varint
    add_byte(8'h81, 1'b1, 1'b1);
    // decoding goes on past list end without a new start
    add_byte(8'h01, 1'b1, 1'b1);
    add_byte(8'h02, 1'b0, 1'b0);
    // list start in the middle of a varint
    add_byte(8'h85, 1'b1, 1'b0);
    add_byte(8'h85, 1'b1, 1'b0);
    add_byte(8'h01, 1'b0, 1'b1);
    lists_built = 6;

    while (byte_queue.size() < TARGET_BYTES) add_random_list();

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (byte_queue.size() != 0 || in_valid) @(posedge clk);
    while (expected_ids.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (expected_ids.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", expected_ids.size()));

    $display("decoded %0d bytes over about %0d lists: %0d ids, %0d overlong, %0d truncated",
             bytes_taken, lists_built, ids_seen, overlong_seen, truncated_seen);
    $display("idle and stall bursts on both channels, %0d mismatches", mismatches);
    if (mismatches == 0) begin
      $display("** varint_delta_posting_decoder: PASSED **");
    end else begin
      $display("** varint_delta_posting_decoder: FAILED **");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/vddp_pkg.sv
design/vddp_in_reg.sv
design/vddp_core.sv
design/vddp_out_reg.sv
design/varint_delta_posting_decoder.sv
design/vddp_checker.sv
verif/varint_delta_posting_decoder_tb.sv
